[rtl/core/cstt_pkg.sv]
// Package for the concurrent search tracking table.
// Holds table geometry, request codes, the controller state type and the
// structures passed between the controller and the set update logic.
package cstt_pkg;

	localparam int SET_COUNT = 4096;
	localparam int WAY_COUNT = 4;
	localparam int SET_BITS = $clog2(SET_COUNT);
	localparam int HASH_W = 64;
	localparam int DEPTH_W = 8;

	localparam logic OP_START = 1'b0;
	localparam logic OP_END = 1'b1;

	localparam logic signed [DEPTH_W-1:0] MIN_DEFER_DEPTH_RST = 8'sd3;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [WAY_COUNT-1:0][HASH_W-1:0] row_t;
	typedef logic [SET_BITS-1:0] set_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic  active;
		logic  op;
		hash_t hash;
	} req_t;

	typedef struct packed {
		logic wr;
		logic defer;
	} upd_t;

endpackage

[rtl/core/cstt_set_logic.sv]
// Compare and update logic for one set of the tracking table.
// Compares all ways against the request hash and forms the new set contents.
// Depends on cstt_pkg.
module cstt_set_logic (
	input  cstt_pkg::req_t req,
	input  cstt_pkg::row_t row_in,
	output cstt_pkg::row_t row_out,
	output cstt_pkg::upd_t upd
);

	logic [cstt_pkg::WAY_COUNT-1:0] hits;
	logic [cstt_pkg::WAY_COUNT-1:0] empties;
	logic [cstt_pkg::WAY_COUNT-1:0] first_empty;
	logic hit;
	logic any_empty;

	always_comb begin
		logic found;
		found = 1'b0;
		for (int w = 0; w < cstt_pkg::WAY_COUNT; w++) begin
			hits[w] = (row_in[w] == req.hash);
			empties[w] = (row_in[w] == '0);
			first_empty[w] = empties[w] && !found;
			found = found || empties[w];
		end
	end

	assign hit = |hits;
	assign any_empty = |empties;

	always_comb begin
		row_out = row_in;
		for (int w = 0; w < cstt_pkg::WAY_COUNT; w++) begin
			if (req.op == cstt_pkg::OP_START) begin
				if (first_empty[w]) begin
					row_out[w] = req.hash;
				end
			end else begin
				if (hits[w]) begin
					row_out[w] = '0;
				end
			end
		end
	end

	always_comb begin
		upd.defer = req.active && (req.op == cstt_pkg::OP_START) && hit;
		if (req.op == cstt_pkg::OP_START) begin
			upd.wr = req.active && !hit && any_empty;
		end else begin
			upd.wr = req.active && hit;
		end
	end

endmodule

[rtl/core/concurrent_search_tracking_table.sv]
// Concurrent search tracking table: set-associative record of hashes under search.
// A taken request and its set row are registered, then done shows the result.
// A new request is not taken until the read then write of one set row is through.
// Reset: the table is swept clear one set per cycle, all 4096 sets, with busy held high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Depends on cstt_pkg and cstt_set_logic.
module concurrent_search_tracking_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [cstt_pkg::HASH_W-1:0]         move_hash,
	input  logic signed [cstt_pkg::DEPTH_W-1:0] depth_left,
	input  logic                                cfg_we,
	input  logic signed [cstt_pkg::DEPTH_W-1:0] cfg_wdata,
	output logic                                done,
	output logic                                defer
);

	cstt_pkg::row_t mem [cstt_pkg::SET_COUNT];

	cstt_pkg::state_t state_q;
	cstt_pkg::state_t state_d;
	cstt_pkg::set_idx_t clr_idx_q;
	logic signed [cstt_pkg::DEPTH_W-1:0] min_defer_depth_q;

	cstt_pkg::req_t req_s1;
	cstt_pkg::set_idx_t set_s1;
	cstt_pkg::row_t row_s1;
	cstt_pkg::row_t row_new;
	cstt_pkg::upd_t upd;

	logic accept;
	logic mem_we;
	cstt_pkg::set_idx_t mem_waddr;
	cstt_pkg::row_t mem_wdata;

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cstt_pkg::ST_CLEAR: begin
				if (clr_idx_q == cstt_pkg::set_idx_t'(cstt_pkg::SET_COUNT - 1)) begin
					state_d = cstt_pkg::ST_IDLE;
				end
			end
			cstt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = cstt_pkg::ST_UPDATE;
				end
			end
			cstt_pkg::ST_UPDATE: begin
				state_d = cstt_pkg::ST_IDLE;
			end
			default: begin
				state_d = cstt_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		mem_we = 1'b0;
		mem_waddr = set_s1;
		mem_wdata = row_new;
		case (state_q)
			cstt_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
			end
			cstt_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			cstt_pkg::ST_UPDATE: begin
				done = 1'b1;
				mem_we = upd.wr;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign defer = done && upd.defer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cstt_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			min_defer_depth_q <= cstt_pkg::MIN_DEFER_DEPTH_RST;
		end else begin
			state_q <= state_d;
			if (state_q == cstt_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cfg_we) begin
				min_defer_depth_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.active <= (depth_left >= min_defer_depth_q) && (move_hash != '0);
			req_s1.op <= op;
			req_s1.hash <= move_hash;
			set_s1 <= move_hash[cstt_pkg::SET_BITS-1:0];
		end
	end

	// A write only happens while busy is high, so it never meets a read for a new transfer.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		row_s1 <= mem[move_hash[cstt_pkg::SET_BITS-1:0]];
	end

	cstt_set_logic u_set_logic (
		.req     (req_s1),
		.row_in  (row_s1),
		.row_out (row_new),
		.upd     (upd)
	);

`ifndef SYNTHESIS
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("Result strobe without a preceding accepted transfer.");

	a_defer_only_start: assert property (@(posedge clk) disable iff (!arst_n)
		defer |-> (done && req_s1.op == cstt_pkg::OP_START && req_s1.active))
		else $error("Defer raised outside an active start request.");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("Table written while a new transfer could be taken.");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cstt_pkg::ST_CLEAR) |-> (busy && !done))
		else $error("Request activity during the clearing sweep.");
`endif

endmodule

[verif/concurrent_search_tracking_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for concurrent_search_tracking_table: start and end transfers
// are predicted against a software copy of the set-associative table and checked per result.
// Depends on cstt_pkg and the table RTL only.
module concurrent_search_tracking_table_tb;
	import cstt_pkg::*;

	localparam int HOT_COUNT = 28;
	localparam int HOT_PER_SET = 7;

	typedef struct {
		logic                       op;
		hash_t                      hash;
		logic signed [DEPTH_W-1:0]  depth;
	} search_req_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       op = OP_START;
	hash_t                      move_hash = '0;
	logic signed [DEPTH_W-1:0]  depth_left = '0;
	logic                       cfg_we = 1'b0;
	logic signed [DEPTH_W-1:0]  cfg_wdata = '0;
	logic                       done;
	logic                       defer;

	hash_t                      search_table [SET_COUNT][WAY_COUNT];
	logic signed [DEPTH_W-1:0]  defer_floor = MIN_DEFER_DEPTH_RST;
	hash_t                      hot_hashes [HOT_COUNT];
	search_req_t                pending_reqs [$];
	logic                       expected_defers [$];
	search_req_t                cur_req;
	logic                       expected_defer_now;
	logic                       allow_gaps = 1'b1;
	int                         sender_gap = 0;
	int                         error_count = 0;

	concurrent_search_tracking_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.move_hash  (move_hash),
		.depth_left (depth_left),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.defer      (defer)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic predict_defer(search_req_t req);
		set_idx_t row;
		logic     hit;
		logic     placed;
		hit = 1'b0;
		placed = 1'b0;
		if (req.depth < defer_floor || req.hash == '0)
			return 1'b0;
		row = set_idx_t'(req.hash % hash_t'(SET_COUNT));
		if (req.op == OP_START) begin
			for (int w = 0; w < WAY_COUNT; w++)
				if (search_table[row][w] == req.hash)
					hit = 1'b1;
			if (!hit) begin
				for (int w = 0; w < WAY_COUNT; w++) begin
					if (!placed && search_table[row][w] == '0) begin
						search_table[row][w] = req.hash;
						placed = 1'b1;
					end
				end
			end
			return hit;
		end
		for (int w = 0; w < WAY_COUNT; w++)
			if (search_table[row][w] == req.hash)
				search_table[row][w] = '0;
		return 1'b0;
	endfunction

	function automatic search_req_t random_req();
		search_req_t r;
		int          pick;
		int          lo;
		r.op = ($urandom_range(99) < 55) ? OP_START : OP_END;
		pick = $urandom_range(99);
		if (pick < 4) begin
			r.hash = '0;
		end else if (pick < 16) begin
			r.hash = {$urandom, $urandom};
		end else begin
			r.hash = hot_hashes[$urandom_range(HOT_COUNT - 1)];
		end
		lo = int'(defer_floor);
		if ($urandom_range(4) == 0) begin
			r.depth = DEPTH_W'($urandom);
		end else begin
			r.depth = DEPTH_W'(lo + int'($urandom_range(127 - lo)));
		end
		return r;
	endfunction

	task automatic push_req(logic req_op, hash_t hash, int depth);
		search_req_t r;
		r.op = req_op;
		r.hash = hash;
		r.depth = DEPTH_W'(depth);
		pending_reqs.push_back(r);
	endtask

	task automatic write_floor(logic signed [DEPTH_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		defer_floor = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_defers.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_phase(logic signed [DEPTH_W-1:0] floor_value, int count);
		write_floor(floor_value);
		repeat (count) pending_reqs.push_back(random_req());
		drain();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_defers.push_back(predict_defer(cur_req));
			end
			if (!start || !busy) begin
				if (sender_gap > 0) begin
					sender_gap--;
					start <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					if (allow_gaps && $urandom_range(7) == 0) begin
						sender_gap = $urandom_range(12, 1) - 1;
						start <= 1'b0;
					end else begin
						cur_req = pending_reqs.pop_front();
						start <= 1'b1;
						op <= cur_req.op;
						move_hash <= cur_req.hash;
						depth_left <= cur_req.depth;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_defers.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual defer=%0b", $time, defer);
				error_count++;
			end else begin
				expected_defer_now = expected_defers.pop_front();
				if (defer !== expected_defer_now) begin
					$display("%0t: defer mismatch, expected %0b, actual %0b",
						$time, expected_defer_now, defer);
					error_count++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL concurrent_search_tracking_table");
		$finish;
	end

	initial begin
		set_idx_t hot_set;
		hash_t    a_hash;
		hash_t    g_hash;
		for (int s = 0; s < SET_COUNT; s++)
			for (int w = 0; w < WAY_COUNT; w++)
				search_table[s][w] = '0;
		// Hashes crowd into four sets so that ways fill, hit and clear often.
		for (int s = 0; s < HOT_COUNT / HOT_PER_SET; s++) begin
			if (s == 0)
				hot_set = '0;
			else if (s == 1)
				hot_set = set_idx_t'(SET_COUNT - 1);
			else
				hot_set = set_idx_t'($urandom_range(SET_COUNT - 2, 1));
			for (int k = 0; k < HOT_PER_SET; k++) begin
				hot_hashes[s * HOT_PER_SET + k] = {$urandom, $urandom};
				hot_hashes[s * HOT_PER_SET + k][SET_BITS-1:0] = hot_set;
				if (hot_hashes[s * HOT_PER_SET + k] == '0)
					hot_hashes[s * HOT_PER_SET + k][HASH_W-1] = 1'b1;
			end
		end
		hot_hashes[HOT_PER_SET] = '1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (!arst_n || busy);

		write_floor(MIN_DEFER_DEPTH_RST);
		a_hash = 64'h8000_0000_0000_0000;
		g_hash = 64'h0000_0000_0000_1000;
		push_req(OP_START, a_hash, 3);
		push_req(OP_START, a_hash, 127);
		push_req(OP_START, a_hash, 2);
		push_req(OP_START, a_hash, -128);
		push_req(OP_END, a_hash, 2);
		push_req(OP_START, a_hash, 3);
		push_req(OP_START, '0, 127);
		push_req(OP_END, '0, 127);
		push_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 50);
		push_req(OP_START, 64'h0000_0000_0000_0FFF, 50);
		push_req(OP_START, 64'h1234_5678_9ABC_DFFF, 50);
		push_req(OP_START, 64'h7FFF_FFFF_FFFF_FFFF, 50);
		push_req(OP_START, 64'h5555_5555_5555_5FFF, 10);
		push_req(OP_START, 64'h5555_5555_5555_5FFF, 10);
		push_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 3);
		push_req(OP_END, 64'h0000_0000_0000_0FFF, 3);
		push_req(OP_START, 64'h5555_5555_5555_5FFF, 3);
		push_req(OP_START, 64'h5555_5555_5555_5FFF, 4);
		push_req(OP_END, g_hash, 127);
		push_req(OP_END, a_hash, 127);
		push_req(OP_START, a_hash, 3);
		push_req(OP_END, 64'hFFFF_FFFF_FFFF_FFFF, -1);
		push_req(OP_START, 64'hFFFF_FFFF_FFFF_FFFF, 100);
		drain();

		random_phase(MIN_DEFER_DEPTH_RST, 150);
		random_phase(-8'sd128, 300);
		random_phase(8'sd127, 150);
		random_phase(8'sd0, 300);
		random_phase(DEPTH_W'($urandom), 300);
		allow_gaps = 1'b0;
		random_phase(MIN_DEFER_DEPTH_RST, 300);

		if (error_count == 0) begin
			$display("PASS concurrent_search_tracking_table");
		end else begin
			$display("FAIL concurrent_search_tracking_table");
		end
		$finish;
	end

endmodule
